// ===== design/jdc_pkg.sv =====
// ---------------------------------------------------------------------------
// jdc_pkg
// Shared widths, constants, reciprocal multipliers, the month offset table and
// the stage load struct of the day number / calendar date converter.
// ---------------------------------------------------------------------------
package jdc_pkg;

   // field widths
   localparam int YEAR_W     = 14;
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int HOUR_W     = 5;
   localparam int MINUTE_W   = 6;
   localparam int SECOND_W   = 6;
   localparam int DN_W       = 23;
   localparam int SOD_W      = 17;
   localparam int OUT_YEAR_W = 15;
   localparam int WDAY_W     = 3;
   // day number inside the pipe, one bit more than the port for the seconds carry
   localparam int Z_W        = 24;

   localparam int STAGES = 7;

   // function codes
   localparam logic FUNC_TO_DAY  = 1'b0;
   localparam logic FUNC_TO_DATE = 1'b1;

   localparam logic [SOD_W-1:0] SECS_PER_DAY = 17'd86400;
   localparam logic [Z_W-1:0]   GREG_START   = 24'd2299161;
   // 1524 less the fixed 2 of the century correction
   localparam logic [Z_W-1:0]   DN_BIAS      = 24'd1522;
   localparam logic [Z_W-1:0]   B_OFFSET     = 24'd1524;
   localparam logic [10:0]      DAYS_4Y      = 11'd1461;
   localparam logic [14:0]      YEAR_OFFSET  = 15'd4716;
   localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;

   // floor(n / d) as (n * ceil(2^k / d)) >> k, exact while n * d < 2^k
   localparam int CENT_SHIFT = 21;
   localparam logic [14:0] CENT_RECIP =
      15'(((64'd1 << CENT_SHIFT) + 64'd99) / 64'd100);

   // alpha = floor((4z - 7468865) / 146097)
   localparam int ALPHA_SHIFT = 43;
   localparam logic [25:0] ALPHA_RECIP =
      26'(((64'd1 << ALPHA_SHIFT) + 64'd146096) / 64'd146097);
   localparam logic [25:0] ALPHA_BIAS = 26'd7468865;

   // c = floor((20b - 2442) / 7305)
   localparam int CYC_SHIFT = 41;
   localparam logic [28:0] CYC_RECIP =
      29'(((64'd1 << CYC_SHIFT) + 64'd7304) / 64'd7305);
   localparam logic [27:0] CYC_BIAS = 28'd2442;

   localparam int WEEK_SHIFT = 27;
   localparam logic [24:0] WEEK_RECIP =
      25'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);

   localparam int HOUR_SHIFT = 29;
   localparam logic [17:0] HOUR_RECIP =
      18'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);

   localparam int MIN_SHIFT = 18;
   localparam logic [12:0] MIN_RECIP =
      13'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);

   // floor(30.6001 * k)
   function automatic logic [8:0] jdc_month_base(input logic [4:0] k);
      logic [8:0] base;
      unique case (k)
         5'd0:    base = 9'd0;
         5'd1:    base = 9'd30;
         5'd2:    base = 9'd61;
         5'd3:    base = 9'd91;
         5'd4:    base = 9'd122;
         5'd5:    base = 9'd153;
         5'd6:    base = 9'd183;
         5'd7:    base = 9'd214;
         5'd8:    base = 9'd244;
         5'd9:    base = 9'd275;
         5'd10:   base = 9'd306;
         5'd11:   base = 9'd336;
         5'd12:   base = 9'd367;
         5'd13:   base = 9'd397;
         5'd14:   base = 9'd428;
         5'd15:   base = 9'd459;
         5'd16:   base = 9'd489;
         default: base = 9'd0;
      endcase
      return base;
   endfunction

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
      logic s7;
   } jdc_load_type;

endpackage

// ===== design/jdc_intf.sv =====
// ---------------------------------------------------------------------------
// jdc request and response channels
// Valid/ready channels carrying one conversion request and one result.
// ---------------------------------------------------------------------------
interface jdc_req_if import jdc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                func;
   logic [YEAR_W-1:0]   year;
   logic [MONTH_W-1:0]  month;
   logic [DAY_W-1:0]    day;
   logic [HOUR_W-1:0]   hour;
   logic [MINUTE_W-1:0] minute;
   logic [SECOND_W-1:0] second;
   logic [DN_W-1:0]     day_number;
   logic [SOD_W-1:0]    seconds_of_day;

   modport source (
      output valid, func, year, month, day, hour, minute, second,
             day_number, seconds_of_day,
      input  ready
   );
   modport sink (
      input  valid, func, year, month, day, hour, minute, second,
             day_number, seconds_of_day,
      output ready
   );
endinterface

interface jdc_rsp_if import jdc_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [DN_W-1:0]             out_day_number;
   logic [SOD_W-1:0]            out_seconds;
   logic signed [OUT_YEAR_W-1:0] out_year;
   logic [MONTH_W-1:0]          out_month;
   logic [DAY_W-1:0]            out_day;
   logic [HOUR_W-1:0]           out_hour;
   logic [MINUTE_W-1:0]         out_minute;
   logic [SECOND_W-1:0]         out_second;
   logic [WDAY_W-1:0]           weekday;

   modport source (
      output valid, out_day_number, out_seconds, out_year, out_month, out_day,
             out_hour, out_minute, out_second, weekday,
      input  ready
   );
   modport sink (
      input  valid, out_day_number, out_seconds, out_year, out_month, out_day,
             out_hour, out_minute, out_second, weekday,
      output ready
   );
endinterface

// ===== design/jdc_ctrl.sv =====
// ---------------------------------------------------------------------------
// jdc_ctrl
// Stage valid bits and per-stage load enables; a stage takes new data when it
// is empty or its content moves on, so bubbles close up under a stall.
// ---------------------------------------------------------------------------
module jdc_ctrl import jdc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   output logic         out_valid,
   input  logic         out_ready,
   output jdc_load_type load
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] ready;
   logic [STAGES-1:0] upstream;
   logic [STAGES-1:0] ld;

   always_comb begin
      ready[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      upstream = {valid_ff[STAGES-2:0], in_valid};
      ld       = ready & upstream;
      valid_in = ld | (~ready & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[STAGES-1];

   assign load.s1 = ld[0];
   assign load.s2 = ld[1];
   assign load.s3 = ld[2];
   assign load.s4 = ld[3];
   assign load.s5 = ld[4];
   assign load.s6 = ld[5];
   assign load.s7 = ld[6];

endmodule

// ===== design/jdc_front.sv =====
// ---------------------------------------------------------------------------
// jdc_front
// Stages 1 and 2: Gregorian date to day number, time of day to seconds, and
// the carry of whole days out of the seconds for both functions.
// ---------------------------------------------------------------------------
module jdc_front import jdc_pkg::*; (
   input  logic                clock,
   input  jdc_load_type        load,
   input  logic                func,
   input  logic [YEAR_W-1:0]   year,
   input  logic [MONTH_W-1:0]  month,
   input  logic [DAY_W-1:0]    day,
   input  logic [HOUR_W-1:0]   hour,
   input  logic [MINUTE_W-1:0] minute,
   input  logic [SECOND_W-1:0] second,
   input  logic [DN_W-1:0]     day_number,
   input  logic [SOD_W-1:0]    seconds_of_day,
   output logic                func_o,
   output logic [Z_W-1:0]      z_o,
   output logic [SOD_W-1:0]    secs_o
);

   // stage 1
   logic              early;
   logic [YEAR_W-1:0] cent_year;
   logic [14:0]       year_shift;
   logic [24:0]       day_prod;
   logic [28:0]       cent_prod;
   logic [4:0]        month_idx;
   logic [SOD_W-1:0]  tod;

   logic              func_s1_ff;
   logic [22:0]       days_s1_ff;
   logic [7:0]        cent_s1_ff;
   logic [8:0]        mbase_s1_ff;
   logic [DAY_W-1:0]  day_s1_ff;
   logic [SOD_W-1:0]  secs_s1_ff;
   logic [DN_W-1:0]   dn_s1_ff;

   // stage 2
   logic              carry;
   logic [SOD_W-1:0]  secs_in;
   logic [Z_W-1:0]    dn_date;
   logic [Z_W-1:0]    z_in;

   logic              func_s2_ff;
   logic [Z_W-1:0]    z_s2_ff;
   logic [SOD_W-1:0]  secs_s2_ff;

   always_comb begin
      // january and february count as months 13 and 14 of the year before
      early      = (month <= MONTH_FEB);
      cent_year  = year;
      if (early) begin
         cent_year = (year == '0) ? '0 : year - 14'd1;
      end
      year_shift = {1'b0, year} + YEAR_OFFSET - {14'd0, early};
      day_prod   = 25'(year_shift) * 25'(DAYS_4Y);
      cent_prod  = 29'(cent_year) * 29'(CENT_RECIP);
      month_idx  = early ? {1'b0, month} + 5'd13 : {1'b0, month} + 5'd1;
      tod        = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
   end

   always_ff @(posedge clock) begin
      if (load.s1) begin
         func_s1_ff  <= func;
         days_s1_ff  <= day_prod[24:2];
         cent_s1_ff  <= cent_prod[28:CENT_SHIFT];
         mbase_s1_ff <= jdc_month_base(month_idx);
         day_s1_ff   <= day;
         secs_s1_ff  <= (func == FUNC_TO_DATE) ? seconds_of_day : tod;
         dn_s1_ff    <= day_number;
      end
   end

   always_comb begin
      carry   = (secs_s1_ff >= SECS_PER_DAY);
      secs_in = carry ? secs_s1_ff - SECS_PER_DAY : secs_s1_ff;
      // century correction 2 - c + c/4, its constant folded into the bias
      dn_date = 24'(days_s1_ff) + 24'(mbase_s1_ff) + 24'(day_s1_ff)
              + 24'(cent_s1_ff[7:2]) - 24'(cent_s1_ff) - DN_BIAS;
      z_in    = ((func_s1_ff == FUNC_TO_DATE) ? 24'(dn_s1_ff) : dn_date) + 24'(carry);
   end

   always_ff @(posedge clock) begin
      if (load.s2) begin
         func_s2_ff <= func_s1_ff;
         z_s2_ff    <= z_in;
         secs_s2_ff <= secs_in;
      end
   end

   assign func_o = func_s2_ff;
   assign z_o    = z_s2_ff;
   assign secs_o = secs_s2_ff;

endmodule

// ===== design/jdc_civil.sv =====
// ---------------------------------------------------------------------------
// jdc_civil
// Stages 3 to 7: day number to year, month and day, Julian calendar before
// the Gregorian reform and Gregorian from it on.
// ---------------------------------------------------------------------------
module jdc_civil import jdc_pkg::*; (
   input  logic                         clock,
   input  jdc_load_type                 load,
   input  logic [Z_W-1:0]               z,
   output logic signed [OUT_YEAR_W-1:0] year_o,
   output logic [MONTH_W-1:0]           month_o,
   output logic [DAY_W-1:0]             day_o
);

   localparam logic [4:0]  E_FIRST    = 5'd4;
   localparam int          E_LOW      = 5;
   localparam int          E_HIGH     = 15;
   localparam logic [4:0]  E_WRAP     = 5'd14;
   localparam logic [15:0] YEAR_LATE  = 16'd4716;
   localparam logic [15:0] YEAR_EARLY = 16'd4715;

   // stage 3
   logic           greg;
   logic [25:0]    n1_full;
   logic [24:0]    n1;
   logic [50:0]    alpha_prod;
   logic [Z_W-1:0] z_s3_ff;
   logic           greg_s3_ff;
   logic [7:0]     alpha_s3_ff;

   // stage 4
   logic [Z_W-1:0] inc;
   logic [Z_W-1:0] b_in;
   logic [27:0]    n2_in;
   logic [Z_W-1:0] b_s4_ff;
   logic [27:0]    n2_s4_ff;

   // stage 5
   logic [56:0]    c_prod;
   logic [Z_W-1:0] b_s5_ff;
   logic [14:0]    c_s5_ff;

   // stage 6
   logic [25:0]    d_prod;
   logic [Z_W-1:0] x_full;
   logic [8:0]     x_s6_ff;
   logic [14:0]    c_s6_ff;

   // stage 7
   logic [4:0]         e_val;
   logic [8:0]         base;
   logic [8:0]         day_full;
   logic [MONTH_W-1:0] month_in;
   logic [15:0]        year_full;

   logic signed [OUT_YEAR_W-1:0] year_s7_ff;
   logic [MONTH_W-1:0]           month_s7_ff;
   logic [DAY_W-1:0]             day_s7_ff;

   always_comb begin
      greg       = (z >= GREG_START);
      n1_full    = {z, 2'b00} - ALPHA_BIAS;
      n1         = greg ? n1_full[24:0] : '0;
      alpha_prod = 51'(n1) * 51'(ALPHA_RECIP);
   end

   always_ff @(posedge clock) begin
      if (load.s3) begin
         z_s3_ff     <= z;
         greg_s3_ff  <= greg;
         alpha_s3_ff <= alpha_prod[50:ALPHA_SHIFT];
      end
   end

   always_comb begin
      inc   = greg_s3_ff ? 24'd1 + 24'(alpha_s3_ff) - 24'(alpha_s3_ff[7:2]) : '0;
      b_in  = z_s3_ff + B_OFFSET + inc;
      // 20b - 2442 is 100b - 12210 scaled down by 5
      n2_in = 28'({b_in, 4'b0000}) + 28'({b_in, 2'b00}) - CYC_BIAS;
   end

   always_ff @(posedge clock) begin
      if (load.s4) begin
         b_s4_ff  <= b_in;
         n2_s4_ff <= n2_in;
      end
   end

   assign c_prod = 57'(n2_s4_ff) * 57'(CYC_RECIP);

   always_ff @(posedge clock) begin
      if (load.s5) begin
         b_s5_ff <= b_s4_ff;
         c_s5_ff <= c_prod[55:CYC_SHIFT];
      end
   end

   always_comb begin
      d_prod = 26'(c_s5_ff) * 26'(DAYS_4Y);
      // days since the start of the march-based year, always within 123..488
      x_full = b_s5_ff - d_prod[25:2];
   end

   always_ff @(posedge clock) begin
      if (load.s6) begin
         x_s6_ff <= x_full[8:0];
         c_s6_ff <= c_s5_ff;
      end
   end

   always_comb begin
      e_val = E_FIRST;
      base  = jdc_month_base(E_FIRST);
      for (int k = E_LOW; k <= E_HIGH; k++) begin
         if (x_s6_ff > jdc_month_base(5'(k))) begin
            e_val = 5'(k);
            base  = jdc_month_base(5'(k));
         end
      end
      day_full  = x_s6_ff - base;
      month_in  = (e_val < E_WRAP) ? 4'(e_val - 5'd1) : 4'(e_val - 5'd13);
      year_full = (month_in > MONTH_FEB) ? {1'b0, c_s6_ff} - YEAR_LATE
                                         : {1'b0, c_s6_ff} - YEAR_EARLY;
   end

   always_ff @(posedge clock) begin
      if (load.s7) begin
         year_s7_ff  <= signed'(year_full[OUT_YEAR_W-1:0]);
         month_s7_ff <= month_in;
         day_s7_ff   <= day_full[DAY_W-1:0];
      end
   end

   assign year_o  = year_s7_ff;
   assign month_o = month_s7_ff;
   assign day_o   = day_s7_ff;

endmodule

// ===== design/jdc_clock.sv =====
// ---------------------------------------------------------------------------
// jdc_clock
// Stages 3 to 7: seconds of day to hour, minute and second, the weekday, and
// the day number and seconds carried along to the result.
// ---------------------------------------------------------------------------
module jdc_clock import jdc_pkg::*; (
   input  logic                clock,
   input  jdc_load_type        load,
   input  logic                func,
   input  logic [Z_W-1:0]      z,
   input  logic [SOD_W-1:0]    secs,
   output logic                func_o,
   output logic [DN_W-1:0]     day_number_o,
   output logic [SOD_W-1:0]    seconds_o,
   output logic [HOUR_W-1:0]   hour_o,
   output logic [MINUTE_W-1:0] minute_o,
   output logic [SECOND_W-1:0] second_o,
   output logic [WDAY_W-1:0]   weekday_o
);

   // stage 3
   logic [Z_W-1:0]      zp1;
   logic [48:0]         week_prod;
   logic [34:0]         hour_prod;
   logic                func_s3_ff;
   logic [Z_W-1:0]      zp1_s3_ff;
   logic [DN_W-1:0]     dn_s3_ff;
   logic [SOD_W-1:0]    secs_s3_ff;
   logic [20:0]         wq_s3_ff;
   logic [HOUR_W-1:0]   hour_s3_ff;

   // stage 4
   logic [Z_W-1:0]      wd_full;
   logic [SOD_W-1:0]    rem_full;
   logic                func_s4_ff;
   logic [DN_W-1:0]     dn_s4_ff;
   logic [SOD_W-1:0]    secs_s4_ff;
   logic [HOUR_W-1:0]   hour_s4_ff;
   logic [11:0]         rem_s4_ff;
   logic [WDAY_W-1:0]   wday_s4_ff;

   // stage 5
   logic [24:0]         min_prod;
   logic                func_s5_ff;
   logic [DN_W-1:0]     dn_s5_ff;
   logic [SOD_W-1:0]    secs_s5_ff;
   logic [HOUR_W-1:0]   hour_s5_ff;
   logic [11:0]         rem_s5_ff;
   logic [MINUTE_W-1:0] min_s5_ff;
   logic [WDAY_W-1:0]   wday_s5_ff;

   // stage 6
   logic [11:0]         sec_full;
   logic                func_s6_ff;
   logic [DN_W-1:0]     dn_s6_ff;
   logic [SOD_W-1:0]    secs_s6_ff;
   logic [HOUR_W-1:0]   hour_s6_ff;
   logic [MINUTE_W-1:0] min_s6_ff;
   logic [SECOND_W-1:0] sec_s6_ff;
   logic [WDAY_W-1:0]   wday_s6_ff;

   // stage 7
   logic                func_s7_ff;
   logic [DN_W-1:0]     dn_s7_ff;
   logic [SOD_W-1:0]    secs_s7_ff;
   logic [HOUR_W-1:0]   hour_s7_ff;
   logic [MINUTE_W-1:0] min_s7_ff;
   logic [SECOND_W-1:0] sec_s7_ff;
   logic [WDAY_W-1:0]   wday_s7_ff;

   always_comb begin
      zp1       = z + 24'd1;
      week_prod = 49'(zp1) * 49'(WEEK_RECIP);
      hour_prod = 35'(secs) * 35'(HOUR_RECIP);
   end

   always_ff @(posedge clock) begin
      if (load.s3) begin
         func_s3_ff <= func;
         zp1_s3_ff  <= zp1;
         dn_s3_ff   <= z[DN_W-1:0];
         secs_s3_ff <= secs;
         wq_s3_ff   <= week_prod[47:WEEK_SHIFT];
         hour_s3_ff <= hour_prod[33:HOUR_SHIFT];
      end
   end

   always_comb begin
      // (z + 1) mod 7, with 7q formed as 8q - q
      wd_full  = zp1_s3_ff - (24'({wq_s3_ff, 3'b000}) - 24'(wq_s3_ff));
      rem_full = secs_s3_ff - 17'(hour_s3_ff) * 17'd3600;
   end

   always_ff @(posedge clock) begin
      if (load.s4) begin
         func_s4_ff <= func_s3_ff;
         dn_s4_ff   <= dn_s3_ff;
         secs_s4_ff <= secs_s3_ff;
         hour_s4_ff <= hour_s3_ff;
         rem_s4_ff  <= rem_full[11:0];
         wday_s4_ff <= wd_full[WDAY_W-1:0];
      end
   end

   assign min_prod = 25'(rem_s4_ff) * 25'(MIN_RECIP);

   always_ff @(posedge clock) begin
      if (load.s5) begin
         func_s5_ff <= func_s4_ff;
         dn_s5_ff   <= dn_s4_ff;
         secs_s5_ff <= secs_s4_ff;
         hour_s5_ff <= hour_s4_ff;
         rem_s5_ff  <= rem_s4_ff;
         min_s5_ff  <= min_prod[23:MIN_SHIFT];
         wday_s5_ff <= wday_s4_ff;
      end
   end

   assign sec_full = rem_s5_ff - 12'(min_s5_ff) * 12'd60;

   always_ff @(posedge clock) begin
      if (load.s6) begin
         func_s6_ff <= func_s5_ff;
         dn_s6_ff   <= dn_s5_ff;
         secs_s6_ff <= secs_s5_ff;
         hour_s6_ff <= hour_s5_ff;
         min_s6_ff  <= min_s5_ff;
         sec_s6_ff  <= sec_full[SECOND_W-1:0];
         wday_s6_ff <= wday_s5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load.s7) begin
         func_s7_ff <= func_s6_ff;
         dn_s7_ff   <= dn_s6_ff;
         secs_s7_ff <= secs_s6_ff;
         hour_s7_ff <= hour_s6_ff;
         min_s7_ff  <= min_s6_ff;
         sec_s7_ff  <= sec_s6_ff;
         wday_s7_ff <= wday_s6_ff;
      end
   end

   assign func_o       = func_s7_ff;
   assign day_number_o = dn_s7_ff;
   assign seconds_o    = secs_s7_ff;
   assign hour_o       = hour_s7_ff;
   assign minute_o     = min_s7_ff;
   assign second_o     = sec_s7_ff;
   assign weekday_o    = wday_s7_ff;

endmodule

// ===== design/julian_day_date_convert.sv =====
// ---------------------------------------------------------------------------
// julian_day_date_convert
// Converts a date and time to a Julian day number counted from midnight, or
// a day number and seconds back to a date and time, with the weekday.
//
//   channel   direction   handshake             carries
//   req_ch    in          valid / ready         func, date, time, day number
//   rsp_ch    out         valid / ready         day number, date, time, weekday
//
// Seven register stages; one item enters every cycle unless a stalled result
// has backed up the pipe, and its result passes through each stage in turn.
// The depth is set by the chain of reciprocal multiplies on the date path
// (alpha, cycle year, days of the cycle year, month). Reset clears only the
// stage valid bits. A stalled result holds the last stage while earlier stages
// keep filling, so a stall closes up bubbles and drops nothing.
// ---------------------------------------------------------------------------
module julian_day_date_convert import jdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   jdc_req_if.sink    req_ch,
   jdc_rsp_if.source  rsp_ch
);

   jdc_load_type load;

   logic           in_ready;
   logic           out_valid;

   logic           func_s2;
   logic [Z_W-1:0] z_s2;
   logic [SOD_W-1:0] secs_s2;

   logic signed [OUT_YEAR_W-1:0] civ_year;
   logic [MONTH_W-1:0]           civ_month;
   logic [DAY_W-1:0]             civ_day;

   logic                func_out;
   logic [DN_W-1:0]     dn_out;
   logic [SOD_W-1:0]    secs_out;
   logic [HOUR_W-1:0]   hour_out;
   logic [MINUTE_W-1:0] min_out;
   logic [SECOND_W-1:0] sec_out;
   logic [WDAY_W-1:0]   wday_out;

   logic to_date;

   jdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (rsp_ch.ready),
      .load      (load)
   );

   jdc_front u_front (
      .clock          (clock),
      .load           (load),
      .func           (req_ch.func),
      .year           (req_ch.year),
      .month          (req_ch.month),
      .day            (req_ch.day),
      .hour           (req_ch.hour),
      .minute         (req_ch.minute),
      .second         (req_ch.second),
      .day_number     (req_ch.day_number),
      .seconds_of_day (req_ch.seconds_of_day),
      .func_o         (func_s2),
      .z_o            (z_s2),
      .secs_o         (secs_s2)
   );

   jdc_civil u_civil (
      .clock   (clock),
      .load    (load),
      .z       (z_s2),
      .year_o  (civ_year),
      .month_o (civ_month),
      .day_o   (civ_day)
   );

   jdc_clock u_clock (
      .clock        (clock),
      .load         (load),
      .func         (func_s2),
      .z            (z_s2),
      .secs         (secs_s2),
      .func_o       (func_out),
      .day_number_o (dn_out),
      .seconds_o    (secs_out),
      .hour_o       (hour_out),
      .minute_o     (min_out),
      .second_o     (sec_out),
      .weekday_o    (wday_out)
   );

   assign to_date = (func_out == FUNC_TO_DATE);

   assign req_ch.ready = in_ready;
   assign rsp_ch.valid = out_valid;

   // date and time fields read as zero for a date to day number transfer
   assign rsp_ch.out_day_number = dn_out;
   assign rsp_ch.out_seconds    = secs_out;
   assign rsp_ch.out_year       = to_date ? civ_year  : '0;
   assign rsp_ch.out_month      = to_date ? civ_month : '0;
   assign rsp_ch.out_day        = to_date ? civ_day   : '0;
   assign rsp_ch.out_hour       = to_date ? hour_out  : '0;
   assign rsp_ch.out_minute     = to_date ? min_out   : '0;
   assign rsp_ch.out_second     = to_date ? sec_out   : '0;
   assign rsp_ch.weekday        = wday_out;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// julian_day_date_convert testbench
// Sends date-to-day-number and day-number-to-date requests through the
// request channel. Each transfer is converted by a behavioral model and the
// result is queued. Every result transfer is compared field by field with
// the oldest queued conversion. Both channels idle at random. The receiver
// also holds off once for a long stretch so the pipe backs up.
// ---------------------------------------------------------------------------
module testbench;
   import jdc_pkg::*;

   localparam int     RANDOM_ITEMS = 1000;
   localparam longint DAY_SECONDS  = 86400;
   localparam longint CYCLE_LIMIT  = 100000;
   localparam int     DRAIN_CYCLES = 24;
   // receiver hold-off that backs up the pipe
   localparam int     HOLD_AT      = 700;
   localparam int     HOLD_CYCLES  = 100;
   // item counts between which neither side idles
   localparam int     CALM_FROM    = 400;
   localparam int     CALM_TO      = 550;

   typedef struct packed {
      logic                func;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [DN_W-1:0]     day_number;
      logic [SOD_W-1:0]    seconds_of_day;
   } convert_request_type;

   typedef struct packed {
      logic [DN_W-1:0]              day_number;
      logic [SOD_W-1:0]             seconds;
      logic signed [OUT_YEAR_W-1:0] year;
      logic [MONTH_W-1:0]           month;
      logic [DAY_W-1:0]             day;
      logic [HOUR_W-1:0]            hour;
      logic [MINUTE_W-1:0]          minute;
      logic [SECOND_W-1:0]          second;
      logic [WDAY_W-1:0]            weekday;
   } convert_result_type;

   logic clock;
   logic reset;

   jdc_req_if req_ch ();
   jdc_rsp_if rsp_ch ();

   julian_day_date_convert DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   convert_request_type pending_requests[$];
   convert_result_type  expected_conversions[$];
   convert_request_type on_bus;
   int                  requests_sent;
   int                  results_seen;
   int                  mismatches;
   longint              cycle_count;
   int                  hold_left;
   bit                  hold_done;

   // calendar conversion, exact integer arithmetic with truncating division
   function automatic convert_result_type convert_calendar(convert_request_type r);
      convert_result_type res;
      longint y, m, cent, dn, secs, alpha, a, b, c, d, e, yr, mo, dy, hh, mm, ss;
      res = '0;
      yr = 0; mo = 0; dy = 0; hh = 0; mm = 0; ss = 0;
      if (r.func == FUNC_TO_DAY) begin
         y = longint'(r.year);
         m = longint'(r.month);
         // january and february count as months 13 and 14 of the year before
         if (m <= 2) begin
            y = y - 1;
            m = m + 12;
         end
         cent = y / 100;
         dn = (1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000 + longint'(r.day)
              + 2 - cent + cent / 4 - 1524;
         secs = longint'(r.hour) * 3600 + longint'(r.minute) * 60 + longint'(r.second);
         dn = dn + secs / DAY_SECONDS;
         secs = secs % DAY_SECONDS;
      end else begin
         dn = longint'(r.day_number);
         secs = longint'(r.seconds_of_day);
         dn = dn + secs / DAY_SECONDS;
         secs = secs % DAY_SECONDS;
         a = dn;
         if (dn >= longint'(GREG_START)) begin
            alpha = (100 * dn - 186721625) / 3652425;
            a = dn + 1 + alpha - alpha / 4;
         end
         b = a + 1524;
         c = (100 * b - 12210) / 36525;
         d = (1461 * c) / 4;
         e = (10000 * (b - d)) / 306001;
         dy = b - d - (306001 * e) / 10000;
         mo = (e < 14) ? e - 1 : e - 13;
         yr = (mo > 2) ? c - 4716 : c - 4715;
         hh = secs / 3600;
         mm = (secs / 60) % 60;
         ss = secs % 60;
      end
      res.day_number = dn[DN_W-1:0];
      res.seconds    = secs[SOD_W-1:0];
      res.year       = yr[OUT_YEAR_W-1:0];
      res.month      = mo[MONTH_W-1:0];
      res.day        = dy[DAY_W-1:0];
      res.hour       = hh[HOUR_W-1:0];
      res.minute     = mm[MINUTE_W-1:0];
      res.second     = ss[SECOND_W-1:0];
      res.weekday    = WDAY_W'((dn + 1) % 7);
      return res;
   endfunction

   function automatic convert_request_type date_request(int y, int mo, int d, int h, int mi,
                                                        int s);
      convert_request_type r;
      r = '0;
      r.func = FUNC_TO_DAY;
      r.year = YEAR_W'(y);
      r.month = MONTH_W'(mo);
      r.day = DAY_W'(d);
      r.hour = HOUR_W'(h);
      r.minute = MINUTE_W'(mi);
      r.second = SECOND_W'(s);
      return r;
   endfunction

   function automatic convert_request_type day_request(int dn, int sod);
      convert_request_type r;
      r = '0;
      r.func = FUNC_TO_DATE;
      r.day_number = DN_W'(dn);
      r.seconds_of_day = SOD_W'(sod);
      return r;
   endfunction

   function automatic convert_request_type random_request();
      convert_request_type r;
      r.func           = 1'($urandom_range(1));
      r.year           = YEAR_W'($urandom);
      r.month          = MONTH_W'($urandom);
      r.day            = DAY_W'($urandom);
      r.hour           = HOUR_W'($urandom);
      r.minute         = MINUTE_W'($urandom);
      r.second         = SECOND_W'($urandom);
      r.day_number     = DN_W'($urandom);
      r.seconds_of_day = SOD_W'($urandom);
      // most items stay in the legal ranges, the rest use the full field widths
      if ($urandom_range(99) >= 15) begin
         r.year   = YEAR_W'($urandom_range(9999, 1));
         r.month  = MONTH_W'($urandom_range(12, 1));
         r.day    = DAY_W'($urandom_range(31, 1));
         r.hour   = HOUR_W'($urandom_range(23));
         r.minute = MINUTE_W'($urandom_range(59));
         r.second = SECOND_W'($urandom_range(59));
         r.seconds_of_day = SOD_W'($urandom_range(86399));
         if ($urandom_range(3) == 0)
            r.day_number = DN_W'(32'(GREG_START) - 32'd400 + $urandom_range(800));
         else
            r.day_number = DN_W'($urandom_range(5373484));
      end
      return r;
   endfunction

   function automatic bit side_idles(int count);
      if (count >= CALM_FROM && count < CALM_TO)
         return 1'b0;
      return ($urandom_range(99) < 23);
   endfunction

   function automatic void check_field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_conversions.push_back(convert_calendar(on_bus));
            requests_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() > 0 && !side_idles(requests_sent)) begin
               on_bus = pending_requests.pop_front();
               req_ch.func           <= on_bus.func;
               req_ch.year           <= on_bus.year;
               req_ch.month          <= on_bus.month;
               req_ch.day            <= on_bus.day;
               req_ch.hour           <= on_bus.hour;
               req_ch.minute         <= on_bus.minute;
               req_ch.second         <= on_bus.second;
               req_ch.day_number     <= on_bus.day_number;
               req_ch.seconds_of_day <= on_bus.seconds_of_day;
               req_ch.valid          <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      convert_result_type exp_res;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_conversions.size() == 0) begin
               $error("result transfer with no conversion pending");
               mismatches++;
            end else begin
               exp_res = expected_conversions.pop_front();
               check_field("out_day_number", longint'(exp_res.day_number),
                           longint'(rsp_ch.out_day_number));
               check_field("out_seconds", longint'(exp_res.seconds),
                           longint'(rsp_ch.out_seconds));
               check_field("out_year", longint'(exp_res.year), longint'(rsp_ch.out_year));
               check_field("out_month", longint'(exp_res.month), longint'(rsp_ch.out_month));
               check_field("out_day", longint'(exp_res.day), longint'(rsp_ch.out_day));
               check_field("out_hour", longint'(exp_res.hour), longint'(rsp_ch.out_hour));
               check_field("out_minute", longint'(exp_res.minute),
                           longint'(rsp_ch.out_minute));
               check_field("out_second", longint'(exp_res.second),
                           longint'(rsp_ch.out_second));
               check_field("weekday", longint'(exp_res.weekday), longint'(rsp_ch.weekday));
            end
         end
         if (!hold_done && results_seen == HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !side_idles(results_seen);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      cycle_count = 0;
      requests_sent = 0;
      results_seen = 0;
      mismatches = 0;
      hold_left = 0;
      hold_done = 1'b0;
      on_bus = '0;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_TO_DAY;
      req_ch.year = '0;
      req_ch.month = '0;
      req_ch.day = '0;
      req_ch.hour = '0;
      req_ch.minute = '0;
      req_ch.second = '0;
      req_ch.day_number = '0;
      req_ch.seconds_of_day = '0;
      rsp_ch.ready = 1'b0;

      // dates to day numbers: range ends, month wrap, unchecked fields
      pending_requests.push_back(date_request(1, 1, 1, 0, 0, 0));
      pending_requests.push_back(date_request(9999, 12, 31, 23, 59, 59));
      pending_requests.push_back(date_request(2000, 1, 1, 12, 0, 0));
      pending_requests.push_back(date_request(2000, 2, 29, 0, 0, 1));
      pending_requests.push_back(date_request(2000, 3, 1, 0, 0, 0));
      pending_requests.push_back(date_request(1582, 10, 15, 0, 0, 0));
      pending_requests.push_back(date_request(1900, 2, 31, 6, 30, 30));
      pending_requests.push_back(date_request(0, 0, 0, 0, 0, 0));
      pending_requests.push_back(date_request(0, 3, 1, 0, 0, 0));
      pending_requests.push_back(date_request(100, 13, 5, 0, 0, 0));
      pending_requests.push_back(date_request(16383, 15, 31, 31, 63, 63));
      pending_requests.push_back(date_request(2024, 6, 15, 24, 0, 0));
      // day numbers to dates: calendar switch, carry of seconds, wrap of fields
      pending_requests.push_back(day_request(0, 0));
      pending_requests.push_back(day_request(2299160, 86399));
      pending_requests.push_back(day_request(2299161, 0));
      pending_requests.push_back(day_request(2299160, 86400));
      pending_requests.push_back(day_request(2451545, 43200));
      pending_requests.push_back(day_request(5373484, 86399));
      pending_requests.push_back(day_request(8388607, 131071));
      pending_requests.push_back(day_request(8388606, 86400));
      pending_requests.push_back(day_request(1721424, 3661));
      pending_requests.push_back(day_request(59, 86399));
      for (int i = 0; i < RANDOM_ITEMS; i++)
         pending_requests.push_back(random_request());

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_ch.valid || expected_conversions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_conversions.size() != 0) begin
         $error("%0d conversions never returned", expected_conversions.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
